// ===== design/bsmm_pkg.sv =====
// Bank-switching memory mapper: shared types and address constants.
// No dependencies; imported by every module of the mapper.
`default_nettype none

package bsmm_pkg;

    // Target codes of a decoded access
    localparam logic [2:0] TGT_MAIN   = 3'd0;
    localparam logic [2:0] TGT_AUX    = 3'd1;
    localparam logic [2:0] TGT_ROM    = 3'd2;
    localparam logic [2:0] TGT_SLOT   = 3'd3;
    localparam logic [2:0] TGT_SWITCH = 3'd4;
    localparam logic [2:0] TGT_NONE   = 3'd5;

    // Access kind
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Soft-switch write selects, address bits [3:1] of $C000-$C00F
    localparam logic [2:0] SW_80STORE   = 3'd0;
    localparam logic [2:0] SW_RAMRD     = 3'd1;
    localparam logic [2:0] SW_RAMWRT    = 3'd2;
    localparam logic [2:0] SW_INTCXROM  = 3'd3;
    localparam logic [2:0] SW_ALTZP     = 3'd4;
    localparam logic [2:0] SW_SLOTC3ROM = 3'd5;
    localparam logic [2:0] SW_80COL     = 3'd6;
    localparam logic [2:0] SW_ALTCHR    = 3'd7;

    // Status read selects, address bits [3:0] of $C010-$C01F
    localparam logic [3:0] ST_KEY      = 4'h0;
    localparam logic [3:0] ST_BANK2    = 4'h1;
    localparam logic [3:0] ST_LCRAM    = 4'h2;
    localparam logic [3:0] ST_RAMRD    = 4'h3;
    localparam logic [3:0] ST_RAMWRT   = 4'h4;
    localparam logic [3:0] ST_INTCXROM = 4'h5;
    localparam logic [3:0] ST_ALTZP    = 4'h6;
    localparam logic [3:0] ST_SLOTC3   = 4'h7;
    localparam logic [3:0] ST_80STORE  = 4'h8;
    localparam logic [3:0] ST_VBL      = 4'h9;
    localparam logic [3:0] ST_TEXT     = 4'hA;
    localparam logic [3:0] ST_MIXED    = 4'hB;
    localparam logic [3:0] ST_PAGE2    = 4'hC;
    localparam logic [3:0] ST_HIRES    = 4'hD;
    localparam logic [3:0] ST_ALTCHR   = 4'hE;
    localparam logic [3:0] ST_80COL    = 4'hF;

    // Display switch bit positions
    localparam int DISP_PAGE2  = 2;
    localparam int DISP_HIRES  = 3;
    localparam int DISP_80COL  = 8;
    localparam int DISP_ALTCHR = 9;

    // Address constants
    localparam logic [15:0] ADDR_RESET_VEC = 16'hFFFC;
    localparam logic [15:0] ADDR_C8_OFF    = 16'hCFFF;
    localparam logic [7:0]  PAGE_STACK     = 8'h01;
    localparam logic [7:0]  PAGE_C3        = 8'hC3;
    localparam logic [11:0] BLK_SWSET      = 12'hC00;
    localparam logic [11:0] BLK_STATUS     = 12'hC01;
    localparam logic [11:0] BLK_DISPLAY    = 12'hC05;
    localparam logic [11:0] BLK_LC         = 12'hC08;
    localparam logic [15:0] ROM_MASK       = 16'h7FFF;
    localparam logic [3:0]  LC_BANK1_HI    = 4'hC;
    localparam logic [3:0]  LC_BANK2_HI    = 4'hD;

    typedef struct packed {
        logic       store80;
        logic       aux_read;
        logic       aux_write;
        logic       int_cx_rom;
        logic       alt_zp;
        logic       slot_c3_rom;
        logic       int_c8_rom;
        logic       lc_bank_one;
        logic       lc_read_en;
        logic       lc_write_en;
        logic [1:0] arm_cnt;
        logic [1:0] stack_cnt;
        logic [9:0] disp;
    } t_state;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        logic        side_eff;
        logic        key_down;
        logic        vblank;
    } t_item;

    typedef struct packed {
        logic [2:0]  target;
        logic [15:0] mem_index;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic        status;
        logic        did_reset;
    } t_result;

endpackage

`default_nettype wire

// ===== design/bank_switching_memory_mapper_unit.sv =====
// An accepted access moves through the input register and the decode into the
// result register, which presents it on the result port until it is taken.
// Throughput: one access per cycle unless the result side stalls; the switch
// state is read and updated in the single decode pass between the two registers,
// so consecutive accesses chain. Reset (synchronous, active low): all switches,
// language-card flags and counts clear, both pipeline stages empty. Depends on bsmm_pkg and bsmm_decode.
`default_nettype none

module bank_switching_memory_mapper_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // access channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire         i_op,
    input  wire  [15:0] i_bus_address,
    input  wire  [7:0]  i_write_data,
    input  wire         i_side_effects,
    input  wire         i_key_down,
    input  wire         i_vblank_active,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [2:0]  o_target,
    output logic [15:0] o_mem_index,
    output logic        o_mem_write,
    output logic [7:0]  o_mem_write_data,
    output logic        o_status_bit,
    output logic        o_did_reset
);
    import bsmm_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_item   r_item;
    t_result r_result;
    t_result dec_result;
    logic    r_in_valid;
    logic    r_out_valid;
    logic    advance;

    // The result register is free when empty or being drained this cycle
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new transfer whenever the input register empties or moves on
    assign o_in_ready = !r_in_valid || advance;

    // Input register: hold the access until the decode can pass it on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.op       <= i_op;
            r_item.addr     <= i_bus_address;
            r_item.wdata    <= i_write_data;
            r_item.side_eff <= i_side_effects;
            r_item.key_down <= i_key_down;
            r_item.vblank   <= i_vblank_active;
        end
    end

    bsmm_decode u_decode (
        .i_state  (r_state),
        .i_item   (r_item),
        .o_result (dec_result),
        .o_state  (n_state)
    );

    // Switch state: advance only when the access really moves into the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: drop the valid once taken, refill from the decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= dec_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_target         = r_result.target;
    assign o_mem_index      = r_result.mem_index;
    assign o_mem_write      = r_result.mem_write;
    assign o_mem_write_data = r_result.mem_wdata;
    assign o_status_bit     = r_result.status;
    assign o_did_reset      = r_result.did_reset;

endmodule

`default_nettype wire

// ===== design/bsmm_decode.sv =====
// Bank-switching memory mapper: single-pass access decode and switch update.
// Depends on bsmm_pkg for the state, item and result structs.
`default_nettype none

module bsmm_decode (
    input  bsmm_pkg::t_state  i_state,
    input  bsmm_pkg::t_item   i_item,
    output bsmm_pkg::t_result o_result,
    output bsmm_pkg::t_state  o_state
);
    import bsmm_pkg::*;

    always_comb begin
        t_state      n;
        t_result     r;
        logic        wr;
        logic        eff;
        logic        lo;
        logic [15:0] a;
        logic        sel;
        logic        c8_was;
        logic [15:0] ram_idx;

        n   = i_state;
        a   = i_item.addr;
        wr  = (i_item.op == OP_WRITE);
        eff = wr | i_item.side_eff;
        lo  = a[0];
        sel = 1'b0;
        c8_was  = 1'b0;
        ram_idx = a;

        r.target    = TGT_NONE;
        r.mem_index = '0;
        r.mem_write = 1'b0;
        r.mem_wdata = '0;
        r.status    = 1'b0;
        r.did_reset = 1'b0;

        // Stack-page watch: three stack reads then a vector fetch resets the MMU
        if (!wr && eff) begin
            if (a[15:8] == PAGE_STACK) begin
                if (n.stack_cnt != 2'd3) begin
                    n.stack_cnt = n.stack_cnt + 2'd1;
                end
            end else begin
                if (n.stack_cnt == 2'd3 && a == ADDR_RESET_VEC) begin
                    n.store80     = 1'b0;
                    n.aux_read    = 1'b0;
                    n.aux_write   = 1'b0;
                    n.int_cx_rom  = 1'b0;
                    n.alt_zp      = 1'b0;
                    n.slot_c3_rom = 1'b0;
                    n.int_c8_rom  = 1'b0;
                    n.lc_bank_one = 1'b0;
                    n.lc_read_en  = 1'b0;
                    n.lc_write_en = 1'b0;
                    n.arm_cnt     = 2'd0;
                    r.did_reset   = 1'b1;
                end
                n.stack_cnt = 2'd0;
            end
        end

        if (a[15:14] != 2'b11) begin
            // Low RAM $0000-$BFFF
            sel = wr ? n.aux_write : n.aux_read;
            if (a[15:9] == 7'd0) begin
                sel = n.alt_zp;
            end else if (a[15:11] == 5'd0 && a[10] && n.store80) begin
                sel = n.disp[DISP_PAGE2];
            end else if (a[15:13] == 3'd1 && n.store80 && n.disp[DISP_HIRES]) begin
                sel = n.disp[DISP_PAGE2];
            end
            r.target    = sel ? TGT_AUX : TGT_MAIN;
            r.mem_index = a;
            r.mem_write = wr;
        end else if (a[15:8] == 8'hC0) begin
            // I/O page
            if (wr && a[15:4] == BLK_SWSET) begin
                case (a[3:1])
                    SW_80STORE:   n.store80           = lo;
                    SW_RAMRD:     n.aux_read          = lo;
                    SW_RAMWRT:    n.aux_write         = lo;
                    SW_INTCXROM:  n.int_cx_rom        = lo;
                    SW_ALTZP:     n.alt_zp            = lo;
                    SW_SLOTC3ROM: n.slot_c3_rom       = lo;
                    SW_80COL:     n.disp[DISP_80COL]  = lo;
                    SW_ALTCHR:    n.disp[DISP_ALTCHR] = lo;
                    default:      n.disp[DISP_ALTCHR] = lo;
                endcase
            end
            if (eff && a[15:4] == BLK_DISPLAY) begin
                n.disp[a[3:1]] = lo;
            end
            if (!wr && a[15:4] == BLK_STATUS) begin
                case (a[3:0])
                    ST_KEY:      r.status = i_item.key_down;
                    ST_BANK2:    r.status = ~n.lc_bank_one;
                    ST_LCRAM:    r.status = n.lc_read_en;
                    ST_RAMRD:    r.status = n.aux_read;
                    ST_RAMWRT:   r.status = n.aux_write;
                    ST_INTCXROM: r.status = n.int_cx_rom;
                    ST_ALTZP:    r.status = n.alt_zp;
                    ST_SLOTC3:   r.status = n.slot_c3_rom;
                    ST_80STORE:  r.status = n.store80;
                    ST_VBL:      r.status = ~i_item.vblank;
                    ST_TEXT:     r.status = n.disp[0];
                    ST_MIXED:    r.status = n.disp[1];
                    ST_PAGE2:    r.status = n.disp[DISP_PAGE2];
                    ST_HIRES:    r.status = n.disp[DISP_HIRES];
                    ST_ALTCHR:   r.status = n.disp[DISP_ALTCHR];
                    ST_80COL:    r.status = n.disp[DISP_80COL];
                    default:     r.status = 1'b0;
                endcase
            end
            if (eff && a[15:4] == BLK_LC) begin
                n.lc_bank_one = a[3];
                n.lc_read_en  = (a[1:0] == 2'd0) || (a[1:0] == 2'd3);
                if (!a[0]) begin
                    n.arm_cnt     = 2'd0;
                    n.lc_write_en = 1'b0;
                end else if (!wr) begin
                    if (n.arm_cnt != 2'd3) begin
                        n.arm_cnt = n.arm_cnt + 2'd1;
                    end
                    if (n.arm_cnt[1]) begin
                        n.lc_write_en = 1'b1;
                    end
                end else begin
                    n.arm_cnt = 2'd0;
                end
            end
            r.target    = TGT_SWITCH;
            r.mem_index = a;
        end else if (a[15:12] == 4'hC) begin
            // Slot / internal ROM space $C100-$CFFF
            if (a[15:8] == PAGE_C3 && eff && !n.slot_c3_rom) begin
                n.int_c8_rom = 1'b1;
            end
            c8_was = n.int_c8_rom;
            if (eff && a == ADDR_C8_OFF) begin
                n.int_c8_rom = 1'b0;
            end
            if ((a[11] && c8_was) || n.int_cx_rom ||
                (!n.slot_c3_rom && a[15:8] == PAGE_C3)) begin
                r.target    = TGT_ROM;
                r.mem_index = {4'h0, a[11:0]};
            end else begin
                r.target    = TGT_SLOT;
                r.mem_index = a;
            end
        end else begin
            // Language card area $D000-$FFFF
            if (a[15:12] == 4'hD) begin
                ram_idx = {(n.lc_bank_one ? LC_BANK1_HI : LC_BANK2_HI), a[11:0]};
            end
            if (!wr) begin
                if (!n.lc_read_en) begin
                    r.target    = TGT_ROM;
                    r.mem_index = a & ROM_MASK;
                end else begin
                    r.target    = n.alt_zp ? TGT_AUX : TGT_MAIN;
                    r.mem_index = ram_idx;
                end
            end else if (n.lc_write_en) begin
                r.target    = n.alt_zp ? TGT_AUX : TGT_MAIN;
                r.mem_index = ram_idx;
                r.mem_write = 1'b1;
            end
        end

        r.mem_wdata = r.mem_write ? i_item.wdata : 8'h00;

        o_result = r;
        o_state  = n;
    end

endmodule

`default_nettype wire

// ===== design/bsmm_checker.sv =====
// Bank-switching memory mapper: port-level checks on the result channel.
// Depends on bsmm_pkg; bound to bank_switching_memory_mapper_unit below.
`default_nettype none

module bsmm_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  o_target,
    input wire [15:0] o_mem_index,
    input wire        o_mem_write,
    input wire [7:0]  o_mem_write_data,
    input wire        o_status_bit,
    input wire        o_did_reset
);
    import bsmm_pkg::*;

    // Hold a stalled result unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_target)
            && $stable(o_mem_index) && $stable(o_mem_write))
        else $error("stalled result changed");

    // An MMU reset leaves the language card reading ROM at the vector
    a_reset_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_reset |-> o_target == TGT_ROM && o_mem_index == 16'h7FFC)
        else $error("reset vector fetch not served from ROM");

    // Only RAM targets take a write strobe
    a_write_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mem_write |-> o_target == TGT_MAIN || o_target == TGT_AUX)
        else $error("write strobe on non-RAM target");

    // Write data is zero without a strobe; status only comes from switch reads
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mem_write || o_mem_write_data == 8'h00)
            && (!o_status_bit || o_target == TGT_SWITCH))
        else $error("stray write data or status bit");

endmodule

bind bank_switching_memory_mapper_unit bsmm_checker u_bsmm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_target         (o_target),
    .o_mem_index      (o_mem_index),
    .o_mem_write      (o_mem_write),
    .o_mem_write_data (o_mem_write_data),
    .o_status_bit     (o_status_bit),
    .o_did_reset      (o_did_reset)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bank_switching_memory_mapper_unit: bus accesses in,
// decoded targets out, checked against a behavioural decoder kept alongside.
// Depends on bsmm_pkg and the mapper RTL.

module tb_top;

    import bsmm_pkg::*;

    // Display bits without a name in the package
    localparam int DISP_TEXT  = 0;
    localparam int DISP_MIXED = 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_op;
    logic [15:0] i_bus_address;
    logic [7:0]  i_write_data;
    logic        i_side_effects;
    logic        i_key_down;
    logic        i_vblank_active;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_target;
    logic [15:0] o_mem_index;
    logic        o_mem_write;
    logic [7:0]  o_mem_write_data;
    logic        o_status_bit;
    logic        o_did_reset;

    bank_switching_memory_mapper_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_bus_address    (i_bus_address),
        .i_write_data     (i_write_data),
        .i_side_effects   (i_side_effects),
        .i_key_down       (i_key_down),
        .i_vblank_active  (i_vblank_active),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_target         (o_target),
        .o_mem_index      (o_mem_index),
        .o_mem_write      (o_mem_write),
        .o_mem_write_data (o_mem_write_data),
        .o_status_bit     (o_status_bit),
        .o_did_reset      (o_did_reset)
    );

    // Soft-switch state mirrored by the decoder below
    t_state  mmu_sw;
    // Decodes predicted at acceptance, oldest first
    t_result pending_decodes[$];
    int      mismatch_count = 0;
    int      accesses_sent  = 0;
    // Random gaps on the access side and stalls on the result side
    logic    idling_on      = 1'b0;

    // ------------------------------------------------------------------
    // Clock, run limit
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog set far beyond the slowest legal run: report failure and stop
    initial begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Behavioural decoder
    // ------------------------------------------------------------------

    // Clear everything the stack-then-vector sequence resets; display state survives
    function automatic void clear_mmu_flags();
        logic [9:0] keep_disp;
        keep_disp   = mmu_sw.disp;
        mmu_sw      = '0;
        mmu_sw.disp = keep_disp;
    endfunction

    // Decode one accepted access, advance the switch state, return the result
    function automatic t_result decode_access(input t_item acc);
        t_result     res;
        logic        wr;
        logic        eff;
        logic        lo;
        logic        aux_sel;
        logic        c8_was;
        logic [15:0] a;
        logic [15:0] ram_idx;
        res        = '0;
        res.target = TGT_NONE;
        a          = acc.addr;
        wr         = (acc.op == OP_WRITE);
        eff        = wr || acc.side_eff;
        lo         = a[0];

        // Stack-page read count; three of them then the reset vector fetch
        // clear the MMU flags. Only reads with side effects count or clear.
        if (!wr && eff) begin
            if (a[15:8] == PAGE_STACK) begin
                if (mmu_sw.stack_cnt != 2'd3)
                    mmu_sw.stack_cnt = mmu_sw.stack_cnt + 2'd1;
            end else begin
                if (mmu_sw.stack_cnt == 2'd3 && a == ADDR_RESET_VEC) begin
                    clear_mmu_flags();
                    res.did_reset = 1'b1;
                end
                mmu_sw.stack_cnt = 2'd0;
            end
        end

        if (a < 16'hC000) begin
            // Main RAM, with zero page, text page and hires page overrides
            aux_sel = wr ? mmu_sw.aux_write : mmu_sw.aux_read;
            if (a < 16'h0200)
                aux_sel = mmu_sw.alt_zp;
            else if (a >= 16'h0400 && a < 16'h0800 && mmu_sw.store80)
                aux_sel = mmu_sw.disp[DISP_PAGE2];
            else if (a >= 16'h2000 && a < 16'h4000 && mmu_sw.store80
                     && mmu_sw.disp[DISP_HIRES])
                aux_sel = mmu_sw.disp[DISP_PAGE2];
            res.target    = aux_sel ? TGT_AUX : TGT_MAIN;
            res.mem_index = a;
            res.mem_write = wr;
        end else if (a < 16'hC100) begin
            // Switch writes take their new value from address bit 0
            if (wr && a[15:4] == BLK_SWSET) begin
                case (a[3:1])
                    SW_80STORE:   mmu_sw.store80     = lo;
                    SW_RAMRD:     mmu_sw.aux_read    = lo;
                    SW_RAMWRT:    mmu_sw.aux_write   = lo;
                    SW_INTCXROM:  mmu_sw.int_cx_rom  = lo;
                    SW_ALTZP:     mmu_sw.alt_zp      = lo;
                    SW_SLOTC3ROM: mmu_sw.slot_c3_rom = lo;
                    SW_80COL:     mmu_sw.disp[DISP_80COL]  = lo;
                    SW_ALTCHR:    mmu_sw.disp[DISP_ALTCHR] = lo;
                    default:      ;
                endcase
            end
            if (eff && a[15:4] == BLK_DISPLAY)
                mmu_sw.disp[a[3:1]] = lo;
            if (!wr && a[15:4] == BLK_STATUS) begin
                case (a[3:0])
                    ST_KEY:      res.status = acc.key_down;
                    ST_BANK2:    res.status = !mmu_sw.lc_bank_one;
                    ST_LCRAM:    res.status = mmu_sw.lc_read_en;
                    ST_RAMRD:    res.status = mmu_sw.aux_read;
                    ST_RAMWRT:   res.status = mmu_sw.aux_write;
                    ST_INTCXROM: res.status = mmu_sw.int_cx_rom;
                    ST_ALTZP:    res.status = mmu_sw.alt_zp;
                    ST_SLOTC3:   res.status = mmu_sw.slot_c3_rom;
                    ST_80STORE:  res.status = mmu_sw.store80;
                    ST_VBL:      res.status = !acc.vblank;
                    ST_TEXT:     res.status = mmu_sw.disp[DISP_TEXT];
                    ST_MIXED:    res.status = mmu_sw.disp[DISP_MIXED];
                    ST_PAGE2:    res.status = mmu_sw.disp[DISP_PAGE2];
                    ST_HIRES:    res.status = mmu_sw.disp[DISP_HIRES];
                    ST_ALTCHR:   res.status = mmu_sw.disp[DISP_ALTCHR];
                    ST_80COL:    res.status = mmu_sw.disp[DISP_80COL];
                    default:     ;
                endcase
            end
            // Language card: even addresses disarm, two odd reads enable writing
            if (eff && a[15:4] == BLK_LC) begin
                mmu_sw.lc_bank_one = a[3];
                mmu_sw.lc_read_en  = (a[1:0] == 2'd0) || (a[1:0] == 2'd3);
                if (!a[0]) begin
                    mmu_sw.arm_cnt     = 2'd0;
                    mmu_sw.lc_write_en = 1'b0;
                end else if (!wr) begin
                    if (mmu_sw.arm_cnt != 2'd3)
                        mmu_sw.arm_cnt = mmu_sw.arm_cnt + 2'd1;
                    if (mmu_sw.arm_cnt >= 2'd2)
                        mmu_sw.lc_write_en = 1'b1;
                end else begin
                    mmu_sw.arm_cnt = 2'd0;
                end
            end
            res.target    = TGT_SWITCH;
            res.mem_index = a;
        end else if (a < 16'hD000) begin
            // Slot space: $C3xx latches the internal $C800 ROM, $CFFF drops it
            if (a[15:8] == PAGE_C3 && eff && !mmu_sw.slot_c3_rom)
                mmu_sw.int_c8_rom = 1'b1;
            c8_was = mmu_sw.int_c8_rom;
            if (eff && a == ADDR_C8_OFF)
                mmu_sw.int_c8_rom = 1'b0;
            if ((a >= 16'hC800 && c8_was) || mmu_sw.int_cx_rom
                || (!mmu_sw.slot_c3_rom && a[15:8] == PAGE_C3)) begin
                res.target    = TGT_ROM;
                res.mem_index = {4'h0, a[11:0]};
            end else begin
                res.target    = TGT_SLOT;
                res.mem_index = a;
            end
        end else begin
            // Language card area; $D000-$DFFF folds onto the selected bank
            ram_idx = a;
            if (a < 16'hE000)
                ram_idx = {mmu_sw.lc_bank_one ? LC_BANK1_HI : LC_BANK2_HI, a[11:0]};
            if (!wr) begin
                if (!mmu_sw.lc_read_en) begin
                    res.target    = TGT_ROM;
                    res.mem_index = a & ROM_MASK;
                end else begin
                    res.target    = mmu_sw.alt_zp ? TGT_AUX : TGT_MAIN;
                    res.mem_index = ram_idx;
                end
            end else if (mmu_sw.lc_write_en) begin
                res.target    = mmu_sw.alt_zp ? TGT_AUX : TGT_MAIN;
                res.mem_index = ram_idx;
                res.mem_write = 1'b1;
            end
        end
        res.mem_wdata = res.mem_write ? acc.wdata : 8'h00;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, compare every transfer with the oldest decode
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idling_on && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual target %h index %h",
                         $time, o_target, o_mem_index);
                mismatch_count++;
            end else begin
                want = pending_decodes.pop_front();
                check_field("target",         16'(want.target),    16'(o_target));
                check_field("mem_index",      want.mem_index,      o_mem_index);
                check_field("mem_write",      16'(want.mem_write), 16'(o_mem_write));
                check_field("mem_write_data", 16'(want.mem_wdata), 16'(o_mem_write_data));
                check_field("status_bit",     16'(want.status),    16'(o_status_bit));
                check_field("did_reset",      16'(want.did_reset), 16'(o_did_reset));
            end
        end
    end

    // ------------------------------------------------------------------
    // Access side
    // ------------------------------------------------------------------

    // Present one access at the falling edge and hold it until the transfer
    task automatic send_access(input t_item acc);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_op            <= acc.op;
        i_bus_address   <= acc.addr;
        i_write_data    <= acc.wdata;
        i_side_effects  <= acc.side_eff;
        i_key_down      <= acc.key_down;
        i_vblank_active <= acc.vblank;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_decodes.push_back(decode_access(acc));
        accesses_sent++;
    endtask

    task automatic issue(input logic op, input logic [15:0] addr,
                         input logic [7:0] data, input logic side_eff);
        t_item acc;
        acc.op       = op;
        acc.addr     = addr;
        acc.wdata    = data;
        acc.side_eff = side_eff;
        acc.key_down = 1'($urandom_range(0, 1));
        acc.vblank   = 1'($urandom_range(0, 1));
        send_access(acc);
    endtask

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    function automatic logic rnd_op();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly real accesses, now and then a debugger peek
    function automatic logic rnd_se();
        return $urandom_range(0, 7) != 0;
    endfunction

    function automatic logic [15:0] rnd_in(input int lo_addr, input int hi_addr);
        return 16'($urandom_range(hi_addr, lo_addr));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_cases();
        issue(OP_READ,  16'h0000, 8'h00, 1'b1);
        issue(OP_WRITE, 16'hFFFF, 8'hFF, 1'b1);   // card write disabled: nothing
        issue(OP_WRITE, 16'hC001, 8'h00, 1'b1);   // 80STORE on via address bit 0
        issue(OP_WRITE, 16'hC055, 8'h5A, 1'b1);   // PAGE2 on
        issue(OP_READ,  16'h0400, 8'h00, 1'b1);   // text page follows PAGE2 into aux
        issue(OP_READ,  16'hC018, 8'h00, 1'b1);
        issue(OP_READ,  16'hC010, 8'h00, 1'b1);   // key flag
        issue(OP_READ,  16'hC019, 8'h00, 1'b1);   // inverted vertical blank
        issue(OP_READ,  16'hC08B, 8'h00, 1'b1);   // first odd read arms
        issue(OP_READ,  16'hC08B, 8'h00, 1'b1);   // second enables writing
        issue(OP_WRITE, 16'hD123, 8'hA5, 1'b1);   // bank one remap
        issue(OP_READ,  16'hD123, 8'h00, 1'b1);
        issue(OP_READ,  16'hC011, 8'h00, 1'b1);
        issue(OP_READ,  16'hC300, 8'h00, 1'b1);   // latch internal C8 ROM
        issue(OP_READ,  16'hC800, 8'h00, 1'b1);
        issue(OP_READ,  16'hCFFF, 8'h00, 1'b1);   // still ROM, then released
        issue(OP_READ,  16'hC800, 8'h00, 1'b0);   // peek: slot
        issue(OP_READ,  16'h0100, 8'h00, 1'b1);   // three stack reads ...
        issue(OP_READ,  16'h0101, 8'h00, 1'b1);
        issue(OP_READ,  16'h01FF, 8'h00, 1'b1);
        issue(OP_READ,  16'hFFFC, 8'h00, 1'b1);   // ... then the vector fetch resets
        issue(OP_READ,  16'hC012, 8'h00, 1'b1);
        issue(OP_READ,  16'hC080, 8'h00, 1'b0);   // peek leaves the card alone
        issue(OP_WRITE, 16'h0000, 8'h00, 1'b1);
    endtask

    // Mostly well-formed sequences with random content, the rest noise
    task automatic random_traffic(input int n_items);
        int          stop_at;
        int          kind;
        int          pick;
        logic [15:0] a;
        stop_at = accesses_sent + n_items;
        while (accesses_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 15) begin
                // Stack reads then the vector; short runs and stray accesses break it
                repeat ($urandom_range(2, 5))
                    issue(OP_READ, {PAGE_STACK, rnd8()}, rnd8(), rnd_se());
                if ($urandom_range(0, 4) == 0)
                    issue(rnd_op(), rnd8() == 8'h00 ? 16'h01F0 : 16'($urandom), rnd8(),
                          rnd_se());
                a = ($urandom_range(0, 5) == 0) ? 16'hFFFD : ADDR_RESET_VEC;
                issue($urandom_range(0, 9) == 0 ? OP_WRITE : OP_READ, a, rnd8(), rnd_se());
            end else if (kind < 32) begin
                // Arm the card with odd reads, sometimes broken, then use it
                issue(OP_READ, {BLK_LC, 4'($urandom_range(0, 15)) | 4'h1}, rnd8(), rnd_se());
                a = {BLK_LC, 4'($urandom_range(0, 15))};
                if ($urandom_range(0, 5) != 0)
                    a[0] = 1'b1;
                issue($urandom_range(0, 6) == 0 ? OP_WRITE : OP_READ, a, rnd8(), rnd_se());
                repeat ($urandom_range(2, 6))
                    issue(rnd_op(), rnd_in(16'hD000, 16'hFFFF), rnd8(), rnd_se());
            end else if (kind < 47) begin
                // Flip one switch, then reach the areas it steers
                issue(OP_WRITE, rnd_in(16'hC000, 16'hC00F), rnd8(), rnd_se());
                repeat ($urandom_range(1, 3)) begin
                    pick = $urandom_range(0, 3);
                    case (pick)
                        0:       a = rnd_in(16'h0000, 16'h01FF);
                        1:       a = rnd_in(16'h0400, 16'h07FF);
                        2:       a = rnd_in(16'h2000, 16'h3FFF);
                        default: a = rnd_in(16'h0000, 16'hBFFF);
                    endcase
                    issue(rnd_op(), a, rnd8(), rnd_se());
                end
            end else if (kind < 57) begin
                issue(rnd_op(), rnd_in(16'hC050, 16'hC05F), rnd8(), rnd_se());
            end else if (kind < 70) begin
                issue($urandom_range(0, 5) == 0 ? OP_WRITE : OP_READ,
                      rnd_in(16'hC010, 16'hC01F), rnd8(), rnd_se());
            end else if (kind < 80) begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       a = rnd_in(16'hC300, 16'hC3FF);
                    1:       a = rnd_in(16'hC800, 16'hCFFE);
                    2:       a = ADDR_C8_OFF;
                    default: a = rnd_in(16'hC100, 16'hCFFF);
                endcase
                issue(rnd_op(), a, rnd8(), rnd_se());
            end else if (kind < 90) begin
                issue(rnd_op(), rnd_in(16'hC080, 16'hC08F), rnd8(), rnd_se());
            end else begin
                issue(rnd_op(), 16'($urandom), rnd8(), rnd_se());
            end
        end
    endtask

    task automatic test_random_with_idling();
        idling_on = 1'b1;
        random_traffic(1150);
    endtask

    // Back-to-back transfers on both sides
    task automatic test_full_rate();
        idling_on = 1'b0;
        random_traffic(200);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        int drain_wait;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = OP_READ;
        i_bus_address   = 16'h0000;
        i_write_data    = 8'h00;
        i_side_effects  = 1'b0;
        i_key_down      = 1'b0;
        i_vblank_active = 1'b0;
        mmu_sw          = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_with_idling();
        test_full_rate();

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain, then keep watching for any stray result
        drain_wait = 0;
        while (pending_decodes.size() != 0 && drain_wait < 2000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && pending_decodes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
